/* rtl/pba_pkg.sv */
package pba_pkg;

  localparam int MaxPagesDefault = 64;

  localparam logic [31:0] PageSizeReset = 32'd2097152;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RECYCLE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_NO_PAGE  = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

endpackage

/* rtl/paged_bump_allocator.sv */
// An accepted transaction is registered into stage s1, its result into the output
// registers once free. One transaction per cycle unless out_ready stalls; the free
// list head link is prefetched from link_mem, so a page pop never waits on a read.
// Reset (rst, synchronous): lists empty, no current page, page_size 2097152,
// both pipeline stages empty. The page link memory is not cleared.
module paged_bump_allocator
  import pba_pkg::*;
#(
  parameter int MAX_PAGES = MaxPagesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] size,
  input  logic [16:0] alignment,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  page_index,
  output logic [31:0] offset,
  output logic [1:0]  status
);

  localparam int PAGE_W = $clog2(MAX_PAGES);
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int LINK_W = PAGE_W + 1;

  logic [31:0] page_size;

  logic        s1_valid;
  logic [1:0]  s1_opcode;
  logic [31:0] s1_size;
  logic [16:0] s1_align;

  logic [PAGE_W-1:0] free_head, free_head_next;
  logic              free_valid, free_valid_next;
  logic [PAGE_W-1:0] used_head, used_head_next;
  logic              used_valid, used_valid_next;
  logic [PAGE_W-1:0] used_tail, used_tail_next;
  logic              tail_valid, tail_valid_next;
  logic [CNT_W-1:0]  pages_created, pages_created_next;
  logic [PAGE_W-1:0] current_page, current_page_next;
  logic              current_valid, current_valid_next;
  logic [31:0]       fill_offset, fill_offset_next;

  logic [LINK_W-1:0] link_mem [MAX_PAGES];
  logic [LINK_W-1:0] link_rd;
  logic              mem_we;
  logic [PAGE_W-1:0] mem_waddr;
  logic [LINK_W-1:0] mem_wdata;

  logic              advance;
  logic [PAGE_W-1:0] res_page;
  logic [PAGE_W+5:0] res_page_ext;
  logic [31:0]       res_offset;
  logic [1:0]        res_status;

  logic [16:0] lowbit;
  logic [16:0] mask;
  logic [32:0] fill_ext;
  logic [32:0] aligned;
  logic [33:0] need;
  logic        too_big;
  logic        need_page;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_comb begin
    lowbit = s1_align & (~s1_align + 17'd1);
    if (lowbit == 17'd0) begin
      lowbit = 17'd1;
    end
    mask     = lowbit - 17'd1;
    fill_ext = {1'b0, fill_offset} + {16'd0, mask};
    aligned  = current_valid ? (fill_ext & ~{16'd0, mask}) : 33'd0;
    need     = {1'b0, aligned} + {2'd0, s1_size};
    too_big  = s1_size > page_size;
    need_page = !current_valid || (need > {2'd0, page_size});
  end

  always_comb begin
    free_head_next     = free_head;
    free_valid_next    = free_valid;
    used_head_next     = used_head;
    used_valid_next    = used_valid;
    used_tail_next     = used_tail;
    tail_valid_next    = tail_valid;
    pages_created_next = pages_created;
    current_page_next  = current_page;
    current_valid_next = current_valid;
    fill_offset_next   = fill_offset;
    mem_we             = 1'b0;
    mem_waddr          = current_page;
    mem_wdata          = {used_valid, used_head};
    res_page           = '0;
    res_offset         = 32'd0;
    res_status         = ST_OK;

    if (advance) begin
      case (s1_opcode)
        OP_ALLOC: begin
          if (too_big) begin
            res_status = ST_TOO_BIG;
          end else if (!need_page) begin
            fill_offset_next = need[31:0];
            res_page         = current_page;
            res_offset       = aligned[31:0];
          end else if (!free_valid && pages_created >= CNT_W'(MAX_PAGES)) begin
            res_status = ST_NO_PAGE;
          end else begin
            if (free_valid) begin
              res_page        = free_head;
              free_head_next  = link_rd[PAGE_W-1:0];
              free_valid_next = link_rd[PAGE_W];
            end else begin
              res_page           = pages_created[PAGE_W-1:0];
              pages_created_next = pages_created + CNT_W'(1);
            end
            if (current_valid) begin
              mem_we          = 1'b1;
              used_head_next  = current_page;
              used_valid_next = 1'b1;
              if (!tail_valid) begin
                used_tail_next  = current_page;
                tail_valid_next = 1'b1;
              end
            end
            current_page_next  = res_page;
            current_valid_next = 1'b1;
            fill_offset_next   = s1_size;
          end
        end
        OP_RELEASE: begin
          if (current_valid) begin
            mem_we          = 1'b1;
            used_head_next  = current_page;
            used_valid_next = 1'b1;
            if (!tail_valid) begin
              used_tail_next  = current_page;
              tail_valid_next = 1'b1;
            end
          end
          current_valid_next = 1'b0;
          current_page_next  = '0;
        end
        OP_RECYCLE: begin
          if (used_valid && tail_valid) begin
            mem_we          = 1'b1;
            mem_waddr       = used_tail;
            mem_wdata       = {free_valid, free_head};
            free_head_next  = used_head;
            free_valid_next = 1'b1;
            used_valid_next = 1'b0;
            tail_valid_next = 1'b0;
            used_head_next  = '0;
            used_tail_next  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_page_ext = {6'd0, res_page};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_we && (mem_waddr == free_head_next)) begin
      link_rd <= mem_wdata;
    end else begin
      link_rd <= link_mem[free_head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size     <= PageSizeReset;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      free_head     <= '0;
      free_valid    <= 1'b0;
      used_head     <= '0;
      used_valid    <= 1'b0;
      used_tail     <= '0;
      tail_valid    <= 1'b0;
      pages_created <= '0;
      current_page  <= '0;
      current_valid <= 1'b0;
      fill_offset   <= 32'd0;
    end else begin
      if (cfg_wr_en) begin
        page_size <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      free_head     <= free_head_next;
      free_valid    <= free_valid_next;
      used_head     <= used_head_next;
      used_valid    <= used_valid_next;
      used_tail     <= used_tail_next;
      tail_valid    <= tail_valid_next;
      pages_created <= pages_created_next;
      current_page  <= current_page_next;
      current_valid <= current_valid_next;
      fill_offset   <= fill_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_opcode <= opcode;
      s1_size   <= size;
      s1_align  <= alignment;
    end
    if (advance) begin
      page_index <= res_page_ext[5:0];
      offset     <= res_offset;
      status     <= res_status;
    end
  end

endmodule

/* rtl/pba_checker.sv */
module pba_checker
  import pba_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  page_index,
  input logic [31:0] offset,
  input logic [1:0]  status
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(page_index) && $stable(offset)
      && $stable(status))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != ST_RESERVED)
    else $error("reserved status code");

  // A failed request carries no page and no offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> page_index == 6'd0 && offset == 32'd0)
    else $error("failed request returned a location");

  // The input side only stalls while a finished result waits downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind paged_bump_allocator pba_checker u_pba_checker (.*);

/* verif/paged_bump_allocator_test.sv */
`timescale 1ns / 1ps

module paged_bump_allocator_test;
  import pba_pkg::*;

  localparam int PageCount = MaxPagesDefault;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int LongStallCycles = 200;
  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 140;

  typedef struct packed {
    logic [5:0]  page;
    logic [31:0] off;
    logic [1:0]  st;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [31:0] size = '0;
  logic [16:0] alignment = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  page_index;
  logic [31:0] offset;
  logic [1:0]  status;

  paged_bump_allocator DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .size(size),
    .alignment(alignment),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .page_index(page_index),
    .offset(offset),
    .status(status)
  );

  initial forever #1 clk = ~clk;

  // Mirror of the allocator state, advanced once per accepted transaction.
  logic [31:0] page_bytes = PageSizeReset;
  logic [5:0]  link_of [PageCount];
  logic        link_ok [PageCount];
  logic [5:0]  free_top = '0;
  logic        free_ok = 1'b0;
  logic [5:0]  used_top = '0;
  logic        used_ok = 1'b0;
  logic [5:0]  used_end = '0;
  logic        used_end_ok = 1'b0;
  int          pages_made = 0;
  logic [5:0]  cur_page = '0;
  logic        cur_ok = 1'b0;
  logic [31:0] fill = '0;

  grant_t expected_grants[$];
  int     mismatch_count = 0;
  bit     idle_on = 1'b1;
  bit     long_stall_req = 1'b0;
  int     quiet_cycles = 0;

  task automatic retire_page(input logic [5:0] pg);
    link_of[pg] = used_top;
    link_ok[pg] = used_ok;
    used_top = pg;
    used_ok = 1'b1;
    if (!used_end_ok) begin
      used_end = pg;
      used_end_ok = 1'b1;
    end
  endtask

  task automatic compute_grant(input logic [1:0] op, input logic [31:0] sz,
                               input logic [16:0] al, output grant_t g);
    logic [63:0] a;
    logic [63:0] aligned;
    logic [5:0]  pg;
    bit          got_page;
    g = '0;
    case (op)
      OP_ALLOC: begin
        if (sz > page_bytes) begin
          g.st = ST_TOO_BIG;
        end else begin
          a = {47'b0, al};
          a = a & (~a + 64'd1);
          if (a == 0) a = 64'd1;
          aligned = '0;
          if (cur_ok) aligned = ({32'b0, fill} + a - 64'd1) & ~(a - 64'd1);
          if (!cur_ok || aligned + {32'b0, sz} > {32'b0, page_bytes}) begin
            got_page = 1'b1;
            pg = '0;
            if (free_ok) begin
              pg = free_top;
              free_ok = link_ok[pg];
              free_top = link_of[pg];
            end else if (pages_made < PageCount) begin
              pg = pages_made[5:0];
              pages_made++;
            end else begin
              got_page = 1'b0;
              g.st = ST_NO_PAGE;
            end
            if (got_page) begin
              if (cur_ok) retire_page(cur_page);
              cur_page = pg;
              cur_ok = 1'b1;
              fill = sz;
              g.page = pg;
            end
          end else begin
            fill = aligned[31:0] + sz;
            g.page = cur_page;
            g.off = aligned[31:0];
          end
        end
      end
      OP_RELEASE: begin
        if (cur_ok) retire_page(cur_page);
        cur_ok = 1'b0;
        cur_page = '0;
      end
      OP_RECYCLE: begin
        if (used_ok && used_end_ok) begin
          link_of[used_end] = free_top;
          link_ok[used_end] = free_ok;
          free_top = used_top;
          free_ok = 1'b1;
          used_ok = 1'b0;
          used_end_ok = 1'b0;
          used_top = '0;
          used_end = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic send_request(input logic [1:0] op, input logic [31:0] sz,
                              input logic [16:0] al);
    int     gap;
    grant_t g;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    size <= sz;
    alignment <= al;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_grant(op, sz, al, g);
    expected_grants.push_back(g);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_page_size(input logic [31:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    page_bytes = value;
  endtask

  task automatic random_request();
    int          pick;
    logic [1:0]  op;
    logic [31:0] sz;
    logic [31:0] lim;
    logic [16:0] al;
    pick = $urandom_range(0, 99);
    if (pick < 70) op = OP_ALLOC;
    else if (pick < 84) op = OP_RELEASE;
    else if (pick < 96) op = OP_RECYCLE;
    else op = OpUnused;
    pick = $urandom_range(0, 99);
    lim = (page_bytes > 32'd64) ? 32'd64 : page_bytes;
    if (pick < 40) begin
      sz = $urandom_range(0, lim);
    end else if (pick < 60) begin
      sz = $urandom_range(0, page_bytes);
    end else if (pick < 70) begin
      sz = (page_bytes >= 32'd3) ? page_bytes - $urandom_range(0, 2) : page_bytes;
    end else if (pick < 80) begin
      sz = (page_bytes != 32'hFFFF_FFFF) ?
           $urandom_range(page_bytes + 32'd1, 32'hFFFF_FFFF) : $urandom;
    end else begin
      sz = $urandom;
    end
    if ($urandom_range(0, 4) != 0) al = 17'd1 << $urandom_range(0, 16);
    else al = 17'($urandom);
    send_request(op, sz, al);
  endtask

  task automatic test_directed();
    send_request(OP_RECYCLE, 32'd0, 17'd1);
    send_request(OP_RELEASE, 32'd0, 17'd1);
    send_request(OpUnused, 32'hFFFF_FFFF, 17'h1FFFF);
    send_request(OP_ALLOC, 32'd0, 17'd1);
    send_request(OP_ALLOC, 32'd100, 17'd1);
    send_request(OP_ALLOC, 32'd8, 17'd65536);
    send_request(OP_ALLOC, 32'd1, 17'd0);
    send_request(OP_ALLOC, 32'd3, 17'h18);
    send_request(OP_ALLOC, 32'd2097152, 17'd1);
    send_request(OP_ALLOC, 32'd2097153, 17'd1);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 17'd1);
    send_request(OP_ALLOC, 32'd0, 17'h1FFFF);
    send_request(OP_RELEASE, 32'd0, 17'd1);
    send_request(OP_RECYCLE, 32'd0, 17'd1);
    send_request(OP_ALLOC, 32'd10, 17'd4);
    send_request(OP_ALLOC, 32'd2097152, 17'd2);
    send_request(OP_RECYCLE, 32'd0, 17'd1);
    write_page_size(32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 17'd1);
    send_request(OP_ALLOC, 32'd0, 17'd65536);
    send_request(OP_ALLOC, 32'd0, 17'd1);
    write_page_size(32'd1);
    send_request(OP_ALLOC, 32'd1, 17'd1);
    send_request(OP_RELEASE, 32'd0, 17'd1);
    send_request(OpUnused, 32'd0, 17'd0);
  endtask

  // With one-byte pages every allocation of one byte needs a fresh page.
  task automatic test_pool_exhaustion();
    write_page_size(32'd1);
    repeat (70) send_request(OP_ALLOC, 32'd1, 17'd1 << $urandom_range(0, 16));
    send_request(OP_ALLOC, 32'd2, 17'd1);
    send_request(OP_ALLOC, 32'd0, 17'd1);
    send_request(OP_RELEASE, 32'd0, 17'd1);
    send_request(OP_RECYCLE, 32'd0, 17'd1);
    repeat (4) send_request(OP_ALLOC, 32'd1, 17'd1);
    send_request(OP_RECYCLE, 32'd0, 17'd1);
    send_request(OP_ALLOC, 32'd1, 17'd1);
  endtask

  task automatic test_backpressure();
    write_page_size(32'd64);
    idle_on = 1'b0;
    long_stall_req = 1'b1;
    repeat (40) random_request();
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    logic [31:0] ps;
    for (int phase = 0; phase < 11; phase++) begin
      case (phase)
        0: ps = 32'd16;
        1: ps = PageSizeReset;
        2: ps = 32'd1;
        3: ps = 32'd4096;
        4: ps = $urandom_range(2, 64);
        5: ps = 32'hFFFF_FFFF;
        6: ps = 32'h8000_0000;
        7: ps = $urandom;
        8: ps = 32'd256;
        9: ps = $urandom_range(1, 8);
        default: ps = 32'd1024;
      endcase
      if (ps == 32'd0) ps = 32'd1;
      write_page_size(ps);
      idle_on = (phase % 4) != 3;
      repeat (PhaseItems) random_request();
    end
    idle_on = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    int     stall;
    grant_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (long_stall_req) begin
        stall = LongStallCycles;
        long_stall_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_grants.size() == 0) begin
        $display("%0t: result with no transaction pending, page_index %0d offset %0d status %0d",
                 $time, page_index, offset, status);
        mismatch_count++;
      end else begin
        want = expected_grants.pop_front();
        check_field("page_index", 32'(want.page), 32'(page_index));
        check_field("offset", want.off, offset);
        check_field("status", 32'(want.st), 32'(status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_pool_exhaustion();
    test_backpressure();
    test_random_mix();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
